// ===== hdl/gtt_pkg.sv =====
// gtt_pkg: shared types and constants for the gb18030 text tokenizer
// holds the byte and token transaction structs and the front-to-back bundle type
// no dependencies
package gtt_pkg;

	localparam int MAX_RESULTS = 6;
	localparam int CNT_W = $clog2(MAX_RESULTS + 1);
	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       message_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       token_last;
		logic       end_marker;
	} out_item_t;

	typedef struct packed {
		out_item_t [MAX_RESULTS-1:0] items;
		logic [CNT_W-1:0]            cnt;
	} bundle_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

// ===== hdl/gtt_front.sv =====
// gtt_front: byte classifier and character segmenter of the tokenizer
// resolves the byte window and produces one bundle of token items per byte
// depends on gtt_pkg
module gtt_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  gtt_pkg::in_item_t in_item,
	output gtt_pkg::bundle_t  bundle
);

	localparam logic [7:0] LEAD_LO      = 8'h81;
	localparam logic [7:0] LEAD_HI      = 8'hfe;
	localparam logic [7:0] DIG_LO       = 8'h30;
	localparam logic [7:0] DIG_HI       = 8'h39;
	localparam logic [7:0] EXT_B_LO     = 8'h95;
	localparam logic [7:0] EXT_B_HI     = 8'h98;
	localparam logic [7:0] GB_LEAD_LO   = 8'hb0;
	localparam logic [7:0] GB_LEAD_HI   = 8'hf7;
	localparam logic [7:0] GB_TRAIL_LO  = 8'ha1;
	localparam logic [7:0] LOW_LEAD_HI  = 8'ha0;
	localparam logic [7:0] HIGH_LEAD_LO = 8'haa;
	localparam logic [7:0] CASE_OFFSET  = 8'h20;

	function automatic logic is_lead(input logic [7:0] b);
		return b >= LEAD_LO && b <= LEAD_HI;
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b >= DIG_LO && b <= DIG_HI;
	endfunction

	function automatic logic is_upper(input logic [7:0] b);
		return b >= 8'h41 && b <= 8'h5a;
	endfunction

	function automatic logic is_letter(input logic [7:0] b);
		return is_upper(b) || (b >= 8'h61 && b <= 8'h7a);
	endfunction

	function automatic logic is_low_trail(input logic [7:0] b);
		return b >= 8'h40 && b <= 8'h7e;
	endfunction

	function automatic logic is_trail(input logic [7:0] b);
		return is_low_trail(b) || (b >= 8'h80 && b <= LEAD_HI);
	endfunction

	function automatic logic keep_four(input logic [7:0] lead);
		return lead == 8'h81 || lead == 8'h82 || (lead >= EXT_B_LO && lead <= EXT_B_HI);
	endfunction

	function automatic logic keep_two(input logic [7:0] lead, input logic [7:0] t);
		logic gb, low, high;
		gb   = lead >= GB_LEAD_LO && lead <= GB_LEAD_HI && t >= GB_TRAIL_LO && t <= LEAD_HI;
		low  = lead >= LEAD_LO && lead <= LOW_LEAD_HI;
		high = lead >= HIGH_LEAD_LO && lead <= LEAD_HI &&
			(is_low_trail(t) || (t >= 8'h80 && t <= LOW_LEAD_HI));
		return gb || low || high;
	endfunction

	logic [7:0] pend_q [3];
	logic [1:0] pcnt_q;
	logic [7:0] held_q;
	logic       held_v_q;

	logic [7:0] pend_d [3];
	logic [1:0] pcnt_d;
	logic [7:0] held_d;
	logic       held_v_d;

	always_comb begin
		logic [7:0] w [4];
		logic [2:0] n;
		logic [2:0] pos;
		logic [2:0] rem;
		logic [2:0] p1;
		logic [2:0] p2;
		logic [2:0] p3;
		logic [2:0] pj;
		logic [2:0] k;
		logic       stop;
		logic       fin;
		logic [7:0] b;
		logic [7:0] hl;
		logic       hlv;

		w[0] = pend_q[0];
		w[1] = pend_q[1];
		w[2] = pend_q[2];
		w[3] = 8'h00;
		w[pcnt_q] = in_item.in_byte;
		n = {1'b0, pcnt_q} + 3'd1;
		fin = in_item.message_last;
		pos = 3'd0;
		k = 3'd0;
		stop = 1'b0;
		hl = held_q;
		hlv = held_v_q;
		b = 8'h00;
		rem = 3'd0;
		p1 = 3'd0;
		p2 = 3'd0;
		p3 = 3'd0;
		pj = 3'd0;
		bundle = '0;

		for (int it = 0; it < 4; it++) begin
			if (!stop && pos < n) begin
				b = w[pos[1:0]];
				rem = n - pos;
				p1 = pos + 3'd1;
				p2 = pos + 3'd2;
				p3 = pos + 3'd3;
				if (is_letter(b)) begin
					if (hlv) begin
						bundle.items[k] = '{out_byte: hl, token_last: 1'b0, end_marker: 1'b0};
						k = k + 3'd1;
					end
					hl = is_upper(b) ? b + CASE_OFFSET : b;
					hlv = 1'b1;
					pos = pos + 3'd1;
				end else begin
					if (hlv) begin
						bundle.items[k] = '{out_byte: hl, token_last: 1'b1, end_marker: 1'b0};
						k = k + 3'd1;
						hlv = 1'b0;
					end
					if (is_lead(b)) begin
						if (rem >= 3'd2 && is_digit(w[p1[1:0]])) begin
							if (rem >= 3'd3 && !is_lead(w[p2[1:0]])) begin
								pos = pos + 3'd1;
							end else if (rem >= 3'd4) begin
								if (is_digit(w[p3[1:0]])) begin
									if (keep_four(b)) begin
										for (int j = 0; j < 4; j++) begin
											pj = pos + 3'(j);
											bundle.items[k] = '{out_byte: w[pj[1:0]],
												token_last: (j == 3), end_marker: 1'b0};
											k = k + 3'd1;
										end
									end
									pos = pos + 3'd4;
								end else begin
									pos = pos + 3'd1;
								end
							end else if (fin) begin
								pos = pos + 3'd1;
							end else begin
								stop = 1'b1;
							end
						end else if (rem < 3'd2) begin
							if (fin) begin
								pos = pos + 3'd1;
							end else begin
								stop = 1'b1;
							end
						end else if (is_trail(w[p1[1:0]])) begin
							if (keep_two(b, w[p1[1:0]])) begin
								bundle.items[k] = '{out_byte: b, token_last: 1'b0, end_marker: 1'b0};
								k = k + 3'd1;
								bundle.items[k] = '{out_byte: w[p1[1:0]], token_last: 1'b1,
									end_marker: 1'b0};
								k = k + 3'd1;
							end
							pos = pos + 3'd2;
						end else begin
							pos = pos + 3'd1;
						end
					end else begin
						if (is_digit(b)) begin
							bundle.items[k] = '{out_byte: b, token_last: 1'b1, end_marker: 1'b0};
							k = k + 3'd1;
						end
						pos = pos + 3'd1;
					end
				end
			end
		end

		if (fin) begin
			if (hlv) begin
				bundle.items[k] = '{out_byte: hl, token_last: 1'b1, end_marker: 1'b0};
				k = k + 3'd1;
			end
			bundle.items[k] = '{out_byte: 8'h00, token_last: 1'b0, end_marker: 1'b1};
			k = k + 3'd1;
			for (int j = 0; j < 3; j++) begin
				pend_d[j] = 8'h00;
			end
			pcnt_d = 2'd0;
			held_d = 8'h00;
			held_v_d = 1'b0;
		end else begin
			for (int j = 0; j < 3; j++) begin
				pj = pos + 3'(j);
				pend_d[j] = (pj < n) ? w[pj[1:0]] : 8'h00;
			end
			rem = n - pos;
			pcnt_d = rem[1:0];
			held_d = hl;
			held_v_d = hlv;
		end
		bundle.cnt = gtt_pkg::CNT_W'(k);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q[0] <= 8'h00;
			pend_q[1] <= 8'h00;
			pend_q[2] <= 8'h00;
			pcnt_q <= 2'd0;
			held_q <= 8'h00;
			held_v_q <= 1'b0;
		end else if (accept) begin
			pend_q[0] <= pend_d[0];
			pend_q[1] <= pend_d[1];
			pend_q[2] <= pend_d[2];
			pcnt_q <= pcnt_d;
			held_q <= held_d;
			held_v_q <= held_v_d;
		end
	end

endmodule

// ===== hdl/gtt_queue.sv =====
// gtt_queue: short bundle queue between the segmenter and the token emitter
// register-based fifo, head entry readable without delay
// depends on gtt_pkg
module gtt_queue #(
	parameter int DEPTH = gtt_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  gtt_pkg::bundle_t    push_data,
	input  logic                pop,
	output gtt_pkg::bundle_t    head,
	output gtt_pkg::q_status_t  status
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	gtt_pkg::bundle_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	assign head = mem_q[rd_ptr_q];
	assign status.full = (count_q == FULL_CNT);
	assign status.empty = (count_q == '0);

endmodule

// ===== hdl/gtt_back.sv =====
// gtt_back: token emitter, walks the head bundle one item per cycle while token_stall is low
// drives the registered token channel and pops finished bundles
// depends on gtt_pkg
module gtt_back (
	input  logic                clk,
	input  logic                arst_n,
	input  gtt_pkg::bundle_t    head,
	input  gtt_pkg::q_status_t  status,
	output logic                pop,
	output logic                token_valid,
	input  logic                token_stall,
	output gtt_pkg::out_item_t  token_data
);

	logic [gtt_pkg::CNT_W-1:0] idx_q;
	logic                      out_valid_q;
	gtt_pkg::out_item_t        out_q;
	logic                      load;
	logic                      at_last;

	assign load = (!out_valid_q || !token_stall) && !status.empty;
	assign at_last = (idx_q + gtt_pkg::CNT_W'(1)) == head.cnt;
	assign pop = load && at_last;

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= head.items[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q <= at_last ? '0 : idx_q + gtt_pkg::CNT_W'(1);
			end else if (!token_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign token_valid = out_valid_q;
	assign token_data = out_q;

`ifndef ASSERT_OFF
	a_marker_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.end_marker) |-> (out_q.out_byte == 8'h00 && !out_q.token_last))
		else $error("end marker carries token data");

	a_idx_in_bundle: assert property (@(posedge clk) disable iff (!arst_n)
		!status.empty |-> (head.cnt != '0 && idx_q < head.cnt))
		else $error("item index outside head bundle");

	a_marker_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(!status.empty && head.items[idx_q].end_marker) |-> at_last)
		else $error("end marker not last item of bundle");
`endif

endmodule

// ===== hdl/gb18030_text_tokenizer.sv =====
// gb18030_text_tokenizer: top level of the gb18030 text tokenizer
// joins segmenter front, bundle queue and token emitter; depends on gtt_pkg
//
// usage:
//   byte channel (byte_valid, byte_stall, byte_data) takes one message byte per
//   transaction; message_last marks the final byte of a message
//   token channel (token_valid, token_stall, token_data) gives token bytes in
//   message order, token_last on the closing byte of each token, and one item
//   with end_marker set after the last token of each message
//   a byte is segmented in the cycle it is accepted and yields zero to six items
//   as one bundle; its first item passes through the bundle queue and then the token
//   output register, if nothing waits ahead of it; letters and partial
//   multibyte characters wait for later bytes of the same message
//   throughput: one byte per cycle in while byte_stall is low, one token item per
//   cycle out while token_stall is low; the emitter walking one bundle item per
//   cycle sets the sustained rate; byte_stall rises when the bundle queue
//   (QUEUE_DEPTH entries) is full, which happens when the receiver stalls or bytes yield more than one item
//   reset empties the queue and clears the output valid flag and any pending bytes or letters
module gb18030_text_tokenizer #(
	parameter int QUEUE_DEPTH = gtt_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_stall,
	input  gtt_pkg::in_item_t  byte_data,
	output logic               token_valid,
	input  logic               token_stall,
	output gtt_pkg::out_item_t token_data
);

	gtt_pkg::bundle_t   fr_bundle;
	gtt_pkg::bundle_t   q_head;
	gtt_pkg::q_status_t q_status;
	logic               accept;
	logic               push;
	logic               pop;

	assign byte_stall = q_status.full;
	assign accept = byte_valid && !q_status.full;
	assign push = accept && (fr_bundle.cnt != '0);

	gtt_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.in_item (byte_data),
		.bundle  (fr_bundle)
	);

	gtt_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (fr_bundle),
		.pop       (pop),
		.head      (q_head),
		.status    (q_status)
	);

	gtt_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (q_head),
		.status      (q_status),
		.pop         (pop),
		.token_valid (token_valid),
		.token_stall (token_stall),
		.token_data  (token_data)
	);

endmodule

// ===== sim/tb_gb18030_text_tokenizer.sv =====
`timescale 1ns / 1ps
// tb_gb18030_text_tokenizer: self-checking testbench for the gb18030 text tokenizer
// predicts token items per accepted byte and checks them in order; depends on gtt_pkg
module tb_gb18030_text_tokenizer;

	localparam int STALL_LIMIT = 1000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               byte_valid = 1'b0;
	logic               byte_stall;
	gtt_pkg::in_item_t  byte_data = '0;
	logic               token_valid;
	logic               token_stall = 1'b0;
	gtt_pkg::out_item_t token_data;

	gtt_pkg::out_item_t expected_tokens[$];
	int        errors = 0;
	int        sent_count = 0;
	int        quiet_cycles = 0;
	int        rx_left = 0;
	bit        tx_idle_en = 1'b1;
	bit        rx_idle_en = 1'b1;

	// predictor state
	logic [7:0] cand_bytes [0:2];
	int         cand_cnt = 0;
	logic [7:0] open_letter = '0;
	bit         open_letter_v = 1'b0;

	gb18030_text_tokenizer i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.byte_data   (byte_data),
		.token_valid (token_valid),
		.token_stall (token_stall),
		.token_data  (token_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit is_lead(logic [7:0] b);
		return b >= 8'h81 && b <= 8'hfe;
	endfunction

	function automatic bit is_digit(logic [7:0] b);
		return b >= 8'h30 && b <= 8'h39;
	endfunction

	function automatic bit is_letter(logic [7:0] b);
		return (b >= 8'h41 && b <= 8'h5a) || (b >= 8'h61 && b <= 8'h7a);
	endfunction

	function automatic bit is_trail(logic [7:0] b);
		return (b >= 8'h40 && b <= 8'h7e) || (b >= 8'h80 && b <= 8'hfe);
	endfunction

	function automatic bit keep_four(logic [7:0] lead);
		return lead == 8'h81 || lead == 8'h82 || (lead >= 8'h95 && lead <= 8'h98);
	endfunction

	function automatic bit keep_two(logic [7:0] lead, logic [7:0] t);
		if (lead >= 8'hb0 && lead <= 8'hf7 && t >= 8'ha1 && t <= 8'hfe)
			return 1'b1;
		if (lead >= 8'h81 && lead <= 8'ha0)
			return 1'b1;
		if (lead >= 8'haa && lead <= 8'hfe &&
				((t >= 8'h40 && t <= 8'h7e) || (t >= 8'h80 && t <= 8'ha0)))
			return 1'b1;
		return 1'b0;
	endfunction

	function automatic void push_token(logic [7:0] b, logic l, logic e);
		gtt_pkg::out_item_t t;
		t.out_byte = b;
		t.token_last = l;
		t.end_marker = e;
		expected_tokens = {expected_tokens, t};
	endfunction

	// segment one accepted byte and queue the token items it produces
	task automatic tokenize_byte(input logic [7:0] b_in, input logic fin);
		logic [7:0] w [0:3];
		logic [7:0] b;
		int n;
		int pos;
		int rem;
		bit stop;
		n = cand_cnt;
		for (int i = 0; i < n; i++)
			w[i] = cand_bytes[i];
		w[n] = b_in;
		n++;
		pos = 0;
		stop = 1'b0;
		while (pos < n && !stop) begin
			b = w[pos];
			rem = n - pos;
			if (is_letter(b)) begin
				if (open_letter_v)
					push_token(open_letter, 1'b0, 1'b0);
				open_letter = (b <= 8'h5a) ? b + 8'h20 : b;
				open_letter_v = 1'b1;
				pos++;
			end else begin
				if (open_letter_v) begin
					push_token(open_letter, 1'b1, 1'b0);
					open_letter_v = 1'b0;
				end
				if (is_lead(b)) begin
					if (rem >= 2 && is_digit(w[pos+1])) begin
						if (rem >= 3 && !is_lead(w[pos+2])) begin
							pos++;
						end else if (rem >= 4) begin
							if (is_digit(w[pos+3])) begin
								if (keep_four(b))
									for (int i = 0; i < 4; i++)
										push_token(w[pos+i], i == 3, 1'b0);
								pos += 4;
							end else begin
								pos++;
							end
						end else if (fin) begin
							pos++;
						end else begin
							stop = 1'b1;
						end
					end else if (rem < 2) begin
						if (fin)
							pos++;
						else
							stop = 1'b1;
					end else if (is_trail(w[pos+1])) begin
						if (keep_two(b, w[pos+1])) begin
							push_token(b, 1'b0, 1'b0);
							push_token(w[pos+1], 1'b1, 1'b0);
						end
						pos += 2;
					end else begin
						pos++;
					end
				end else begin
					if (is_digit(b))
						push_token(b, 1'b1, 1'b0);
					pos++;
				end
			end
		end
		if (fin) begin
			if (open_letter_v)
				push_token(open_letter, 1'b1, 1'b0);
			push_token(8'h00, 1'b0, 1'b1);
			cand_cnt = 0;
			open_letter = '0;
			open_letter_v = 1'b0;
			for (int i = 0; i < 3; i++)
				cand_bytes[i] = '0;
		end else begin
			cand_cnt = 0;
			for (int i = pos; i < n && cand_cnt < 3; i++) begin
				cand_bytes[cand_cnt] = w[i];
				cand_cnt++;
			end
			for (int i = cand_cnt; i < 3; i++)
				cand_bytes[i] = '0;
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input logic fin);
		gtt_pkg::in_item_t item;
		int gap;
		item.in_byte = b;
		item.message_last = fin;
		if (tx_idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 4);
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_data <= item;
		do @(posedge clk); while (byte_stall);
		tokenize_byte(b, fin);
		sent_count++;
	endtask

	task automatic send_message(input logic [7:0] msg [$]);
		foreach (msg[i])
			send_byte(msg[i], i == msg.size() - 1);
	endtask

	task automatic test_ascii;
		send_message('{8'h41, 8'h7a, 8'h5a, 8'h30, 8'h39, 8'h20});
	endtask

	task automatic test_four_byte;
		// kept, then dropped for an outside lead
		send_message('{8'h81, 8'h30, 8'hfe, 8'h39, 8'h83, 8'h30, 8'h81, 8'h30});
	endtask

	task automatic test_two_byte;
		send_message('{8'hb0, 8'ha1, 8'hfe, 8'h40, 8'hfe, 8'hfe, 8'h80, 8'hff});
	endtask

	task automatic test_broken_sequences;
		// lead digit non-lead, lead with bad trail, lead digit lead at message end
		send_message('{8'h81, 8'h30, 8'h41, 8'h90, 8'h20, 8'h82, 8'h31, 8'h82});
		// lone lead as the final byte
		send_message('{8'hc0});
	endtask

	task automatic append_byte(ref logic [7:0] msg [$], input int unsigned v);
		msg = {msg, v[7:0]};
	endtask

	task automatic add_piece(ref logic [7:0] msg [$]);
		int kind;
		int len;
		kind = $urandom_range(0, 9);
		case (kind)
			0: begin
				append_byte(msg, $urandom_range(8'hb0, 8'hf7));
				append_byte(msg, $urandom_range(8'ha1, 8'hfe));
			end
			1: begin
				append_byte(msg, $urandom_range(8'h81, 8'ha0));
				append_byte(msg, $urandom_range(0, 1) ? $urandom_range(8'h40, 8'h7e)
					: $urandom_range(8'h80, 8'hfe));
			end
			2: begin
				append_byte(msg, $urandom_range(8'haa, 8'hfe));
				append_byte(msg, $urandom_range(0, 1) ? $urandom_range(8'h40, 8'h7e)
					: $urandom_range(8'h80, 8'ha0));
			end
			3: begin
				case ($urandom_range(0, 2))
					0: append_byte(msg, $urandom_range(8'h81, 8'h82));
					1: append_byte(msg, $urandom_range(8'h95, 8'h98));
					default: append_byte(msg, $urandom_range(8'h81, 8'hfe));
				endcase
				append_byte(msg, $urandom_range(8'h30, 8'h39));
				append_byte(msg, $urandom_range(8'h81, 8'hfe));
				append_byte(msg, $urandom_range(8'h30, 8'h39));
			end
			4: begin
				len = $urandom_range(1, 4);
				repeat (len)
					append_byte(msg, ($urandom_range(0, 1) ? 32'h41 : 32'h61)
						+ $urandom_range(0, 25));
			end
			5: append_byte(msg, $urandom_range(8'h30, 8'h39));
			6: begin
				append_byte(msg, $urandom_range(8'h81, 8'hfe));
				append_byte(msg, $urandom_range(8'h40, 8'hfe));
			end
			7: begin
				append_byte(msg, $urandom_range(8'h81, 8'hfe));
				if ($urandom_range(0, 1)) begin
					append_byte(msg, $urandom_range(8'h30, 8'h39));
					append_byte(msg, $urandom_range(0, 255));
				end
			end
			default: append_byte(msg, $urandom_range(0, 255));
		endcase
	endtask

	task automatic test_random_messages;
		logic [7:0] msg [$];
		int pieces;
		while (sent_count < 130) begin
			msg.delete();
			pieces = $urandom_range(1, 5);
			repeat (pieces)
				add_piece(msg);
			// stretch without idle gaps or token stalls in the middle and at the end of the run
			tx_idle_en = !(sent_count >= 60 && sent_count < 75) && sent_count < 105;
			rx_idle_en = tx_idle_en;
			send_message(msg);
		end
	endtask

	always @(posedge clk) begin
		if (rx_left > 0) begin
			token_stall <= 1'b1;
			rx_left <= rx_left - 1;
		end else if (token_stall) begin
			token_stall <= 1'b0;
		end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
			token_stall <= 1'b1;
			rx_left <= $urandom_range(0, 3);
		end
	end

	always @(posedge clk) begin
		gtt_pkg::out_item_t want;
		if (token_valid && !token_stall) begin
			if (expected_tokens.size() == 0) begin
				$display("%0t: unexpected token transaction, expected none, actual %h/%b/%b",
					$time, token_data.out_byte, token_data.token_last, token_data.end_marker);
				errors++;
			end else begin
				want = expected_tokens.pop_front();
				if (token_data.out_byte !== want.out_byte) begin
					$display("%0t: out_byte mismatch, expected %h, actual %h",
						$time, want.out_byte, token_data.out_byte);
					errors++;
				end
				if (token_data.token_last !== want.token_last) begin
					$display("%0t: token_last mismatch, expected %b, actual %b",
						$time, want.token_last, token_data.token_last);
					errors++;
				end
				if (token_data.end_marker !== want.end_marker) begin
					$display("%0t: end_marker mismatch, expected %b, actual %b",
						$time, want.end_marker, token_data.end_marker);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((byte_valid && !byte_stall) || (token_valid && !token_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("%0t: watchdog timeout, %0d token transactions outstanding",
				$time, expected_tokens.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < 3; i++)
			cand_bytes[i] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_ascii();
		test_four_byte();
		test_two_byte();
		test_broken_sequences();
		test_random_messages();
		byte_valid <= 1'b0;
		while (expected_tokens.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0 && expected_tokens.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
